// ===== rtl/core/atfd_pkg.sv =====
package atfd_pkg;

  // Window lengths, as powers of two.
  localparam int unsigned MEAS_LOG2 = 3;
  localparam int unsigned CAL_LOG2  = 4;

  // Field and accumulator widths.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LANE_W     = 17;
  localparam int unsigned SUM_W      = 24;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned OFF_W      = 17;
  localparam int unsigned CORR_W     = 18;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned BIAS_W     = 15;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] MEAS_LEN = CNT_W'(1 << MEAS_LOG2);
  localparam logic [CNT_W-1:0] CAL_LEN  = CNT_W'(1 << CAL_LOG2);
  localparam logic [CNT_W-1:0] WIN_MAX  = (MEAS_LEN > CAL_LEN) ? MEAS_LEN : CAL_LEN;

  // Register reset values.
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(5120);
  localparam logic [BIAS_W-1:0] BIAS_RESET = BIAS_W'(10042);

  typedef enum logic [1:0] {
    KIND_ORIENT = 2'd0,
    KIND_CAL    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ORI_UNKNOWN = 2'd0,
    ORI_NORMAL  = 2'd1,
    ORI_UPSIDE  = 2'd2,
    ORI_SIDE    = 2'd3
  } ori_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLIP_THRESHOLD = 2'd0,
    CFG_MOUNT_INVERTED = 2'd1,
    CFG_GRAVITY_BIAS   = 2'd2
  } cfg_idx_e;

  // Control shared by all accumulator lanes.
  typedef struct packed {
    logic en;       // a word is accepted
    logic restart;  // the open window is dropped before this word adds
    logic close;    // the window ends with this word
  } lane_ctl_t;

  // A finished window handed from the lanes to the merging stage.
  typedef struct packed {
    kind_e            kind;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [SUM_W-1:0] sum_z;
  } win_t;

  // One report word.
  typedef struct packed {
    logic [OFF_W-1:0]  off_z;
    logic [OFF_W-1:0]  off_y;
    logic [OFF_W-1:0]  off_x;
    logic [CORR_W-1:0] corr;
    logic              flip;
    ori_e              ori;
  } res_t;

endpackage

// ===== rtl/core/atfd_lane.sv =====
module atfd_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  atfd_pkg::lane_ctl_t                 ctl_i,
  input  logic signed [atfd_pkg::LANE_W-1:0]  sample_i,
  output logic signed [atfd_pkg::SUM_W-1:0]   sum_nxt_o
);
  import atfd_pkg::*;

  logic signed [SUM_W-1:0] sum_q;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] sample_ext;

  // Running sum including the current word.
  assign base       = ctl_i.restart ? '0 : sum_q;
  assign sample_ext = {{(SUM_W-LANE_W){sample_i[LANE_W-1]}}, sample_i};
  assign sum_nxt_o  = base + sample_ext;

  // The sum starts afresh once a window closes or is aborted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctl_i.en) begin
      sum_q <= ctl_i.close ? '0 : sum_nxt_o;
    end
  end

endmodule

// ===== rtl/core/atfd_merge.sv =====
module atfd_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  atfd_pkg::win_t                 win_i,
  input  logic [atfd_pkg::THR_W-1:0]     thr_i,
  input  logic                           inv_i,
  output atfd_pkg::res_t                 res_o
);
  import atfd_pkg::*;

  logic signed [SUM_W-1:0]  avg_meas;
  logic signed [SUM_W-1:0]  avg_x;
  logic signed [SUM_W-1:0]  avg_y;
  logic signed [SUM_W-1:0]  avg_z;
  logic signed [CORR_W-1:0] corr;
  logic signed [CORR_W:0]   corr_w;
  logic signed [CORR_W:0]   thr_w;
  logic                     at_top;
  logic                     at_bottom;
  ori_e                     ori;
  logic                     flip;
  logic [OFF_W-1:0]         off_x_q;
  logic [OFF_W-1:0]         off_y_q;
  logic [OFF_W-1:0]         off_z_q;
  ori_e                     last_q;
  res_t                     res_d;
  res_t                     res_q;

  // Floor averages: an arithmetic shift rounds toward minus infinity.
  assign avg_meas = $signed(win_i.sum_z) >>> MEAS_LOG2;
  assign avg_x    = $signed(win_i.sum_x) >>> CAL_LOG2;
  assign avg_y    = $signed(win_i.sum_y) >>> CAL_LOG2;
  assign avg_z    = $signed(win_i.sum_z) >>> CAL_LOG2;

  // Offset correction and threshold compare.
  assign corr   = $signed(avg_meas[CORR_W-1:0]) - $signed({off_z_q[OFF_W-1], off_z_q});
  assign corr_w = {corr[CORR_W-1], corr};
  assign thr_w  = $signed({{(CORR_W+1-THR_W){1'b0}}, thr_i});
  assign at_top    = corr_w >= thr_w;
  assign at_bottom = corr_w <= -thr_w;

  always_comb begin
    if (at_top) begin
      ori = inv_i ? ORI_UPSIDE : ORI_NORMAL;
    end else if (at_bottom) begin
      ori = inv_i ? ORI_NORMAL : ORI_UPSIDE;
    end else begin
      ori = ORI_SIDE;
    end
    flip = ((ori == ORI_NORMAL) || (ori == ORI_UPSIDE)) && (ori != last_q);
  end

  // Offsets and the last recorded orientation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
      last_q  <= ORI_UNKNOWN;
    end else if (load_i) begin
      if (win_i.kind == KIND_CAL) begin
        off_x_q <= avg_x[OFF_W-1:0];
        off_y_q <= avg_y[OFF_W-1:0];
        off_z_q <= avg_z[OFF_W-1:0];
      end else if ((win_i.kind == KIND_ORIENT) && flip) begin
        last_q <= ori;
      end
    end
  end

  // Next report word; unused fields read as zero.
  always_comb begin
    res_d = '0;
    case (win_i.kind)
      KIND_ORIENT: begin
        res_d.ori  = ori;
        res_d.flip = flip;
        res_d.corr = corr;
      end
      KIND_CAL: begin
        res_d.off_x = avg_x[OFF_W-1:0];
        res_d.off_y = avg_y[OFF_W-1:0];
        res_d.off_z = avg_z[OFF_W-1:0];
      end
      default: begin
        res_d.ori = ORI_UNKNOWN;
      end
    endcase
  end

  // Report word register.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/averaged_tilt_flip_detector_core.sv =====
// Averaged tilt and flip detector.
// Input words arrive on the s_axis channel: tdata carries the x, y and z
// accelerations, tuser the operation (measurement or calibration) and the
// sensor error flag. A measurement window of 8 words yields one orientation
// report; a calibration window of 16 words yields new offsets. A word with
// the error flag aborts the open window and yields an error report at once.
// Reports leave on the m_axis channel, with the report kind in tuser.
// One word is accepted every cycle while s_axis_tready is high. The three axis
// lanes accumulate as the word is taken; a finished window is held in a
// window register and the merging stage turns it into a report in the
// output register.
// If the receiver stalls, one report waits in the output register and one
// finished window in the window register; words are taken until both
// registers are full, and then s_axis_tready stays low until the receiver
// takes the waiting report.
// Reset clears sums, count, offsets and the last orientation, and loads the
// threshold (5120), the normal mount and the gravity bias (10042).
// Configuration writes take effect on the next cycle. The user must make them
// while the block is idle; the block itself does not enforce this.
module averaged_tilt_flip_detector_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input words.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: accel_x, accel_y, accel_z.
  input  logic [47:0]                           s_axis_tdata,
  // tuser: operation, sample_error.
  input  logic [1:0]                            s_axis_tuser,
  // Report words.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata: orientation, flip_seen, corrected_z, offset_x_out, offset_y_out,
  // offset_z_out.
  output logic [71:0]                           m_axis_tdata,
  // tuser: report_kind.
  output logic [1:0]                            m_axis_tuser,
  // Configuration writes.
  input  logic                                  cfg_we_i,
  input  logic [atfd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [atfd_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import atfd_pkg::*;

  logic                     accept;
  logic                     advance;
  logic                     op;
  logic                     err;
  logic signed [SAMPLE_W-1:0] ax;
  logic signed [SAMPLE_W-1:0] ay;
  logic signed [SAMPLE_W-1:0] az;
  logic                     restart;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     done;
  lane_ctl_t                ctl;
  logic signed [LANE_W-1:0] smp_x;
  logic signed [LANE_W-1:0] smp_y;
  logic signed [LANE_W-1:0] smp_z;
  logic signed [SUM_W-1:0]  nxt_x;
  logic signed [SUM_W-1:0]  nxt_y;
  logic signed [SUM_W-1:0]  nxt_z;
  logic [CNT_W-1:0]         count_q;
  logic                     mode_q;
  logic                     s1_valid_q;
  win_t                     s1_q;
  logic                     m_valid_q;
  res_t                     res;
  kind_e                    kind_q;
  logic [THR_W-1:0]         thr_q;
  logic                     inv_q;
  logic [BIAS_W-1:0]        bias_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      inv_q  <= 1'b0;
      bias_q <= BIAS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLIP_THRESHOLD: thr_q  <= cfg_data_i[THR_W-1:0];
        CFG_MOUNT_INVERTED: inv_q  <= cfg_data_i[0];
        CFG_GRAVITY_BIAS:   bias_q <= cfg_data_i[BIAS_W-1:0];
        default: begin
          thr_q <= thr_q;
        end
      endcase
    end
  end

  // Handshake: the window register drains into the output register.
  assign advance       = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Input word fields.
  assign op  = s_axis_tuser[0];
  assign err = s_axis_tuser[1];
  assign ax  = $signed(s_axis_tdata[15:0]);
  assign ay  = $signed(s_axis_tdata[31:16]);
  assign az  = $signed(s_axis_tdata[47:32]);

  // Window bookkeeping: a change of operation drops the open window.
  assign restart = (count_q != '0) && (op != mode_q);
  assign cnt_nxt = (restart ? '0 : count_q) + CNT_W'(1);
  assign done    = op ? (cnt_nxt == CAL_LEN) : (cnt_nxt == MEAS_LEN);

  assign ctl.en      = accept;
  assign ctl.restart = restart;
  assign ctl.close   = err || done;

  // Lane samples; x and y add zero during measurement so they stay clear.
  assign smp_x = op ? {ax[SAMPLE_W-1], ax} : '0;
  assign smp_y = op ? {ay[SAMPLE_W-1], ay} : '0;
  assign smp_z = op ? ({az[SAMPLE_W-1], az} + $signed({2'b00, bias_q}))
                    : {az[SAMPLE_W-1], az};

  atfd_lane u_lane_x (.clk_i, .rst_ni, .ctl_i(ctl), .sample_i(smp_x), .sum_nxt_o(nxt_x));
  atfd_lane u_lane_y (.clk_i, .rst_ni, .ctl_i(ctl), .sample_i(smp_y), .sum_nxt_o(nxt_y));
  atfd_lane u_lane_z (.clk_i, .rst_ni, .ctl_i(ctl), .sample_i(smp_z), .sum_nxt_o(nxt_z));

  // Sample count and window operation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mode_q  <= 1'b0;
    end else if (accept) begin
      count_q <= (err || done) ? '0 : cnt_nxt;
      if (!err) begin
        mode_q <= op;
      end
    end
  end

  // Window register holding a finished or aborted window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept && (err || done)) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (err || done)) begin
      s1_q.kind  <= err ? KIND_ERROR : (op ? KIND_CAL : KIND_ORIENT);
      s1_q.sum_x <= nxt_x;
      s1_q.sum_y <= nxt_y;
      s1_q.sum_z <= nxt_z;
    end
  end

  atfd_merge u_merge (
    .clk_i,
    .rst_ni,
    .load_i (advance),
    .win_i  (s1_q),
    .thr_i  (thr_q),
    .inv_i  (inv_q),
    .res_o  (res)
  );

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  // Kind travels alongside the report word through the output register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q <= s1_q.kind;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = res;
  assign m_axis_tuser  = kind_q;

  // The sample count never reaches a full window.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < WIN_MAX)
    else $error("sample count reached a full window");

  // A stalled window stays in place.
  a_win_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_q))
    else $error("window register changed while stalled");

  // An error word always clears the window.
  a_err_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && err |=> (count_q == '0) && s1_valid_q)
    else $error("error word did not clear the window");

  // Input back-pressure only when both registers are full.
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && m_valid_q)
    else $error("input stalled with a free register");

endmodule
